/* hw/rtl/eau_pkg.sv */
`default_nettype none

package eau_pkg;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IMM  = 4'd0,
    MODE_ZP   = 4'd1,
    MODE_ZPX  = 4'd2,
    MODE_ZPY  = 4'd3,
    MODE_ABS  = 4'd4,
    MODE_ABSX = 4'd5,
    MODE_ABSY = 4'd6,
    MODE_IND  = 4'd7,
    MODE_INDX = 4'd8,
    MODE_INDY = 4'd9
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OP_LO  = 3'd1,
    PH_OP_HI  = 3'd2,
    PH_PTR_LO = 3'd3,
    PH_PTR_HI = 3'd4
  } phase_e;

  localparam logic [7:0] PageLastByte = 8'hFF;

  typedef struct packed {
    logic        op;
    logic [3:0]  mode;
    logic [15:0] pc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  read_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] bus_address;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  active_mode;
    logic [15:0] saved_pc;
    logic [7:0]  saved_index;
    logic [7:0]  low_byte;
    logic [15:0] pointer_address;
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/eau_step.sv */
`default_nettype none

module eau_step (
  input  eau_pkg::state_t st_i,
  input  eau_pkg::in_t    item_i,
  output eau_pkg::state_t st_o,
  output logic            emit_o,
  output eau_pkg::out_t   res_o
);

  logic [7:0]  b;
  logic [7:0]  zp_sum;
  logic [15:0] word;

  assign b      = item_i.read_byte;
  assign zp_sum = b + st_i.saved_index;
  assign word   = {b, st_i.low_byte};

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    res_o  = '0;
    if (item_i.op == eau_pkg::OP_START) begin
      if (st_i.phase == eau_pkg::PH_IDLE &&
          item_i.mode inside {[eau_pkg::MODE_IMM:eau_pkg::MODE_INDY]}) begin
        st_o.active_mode = item_i.mode;
        st_o.saved_pc    = item_i.pc;
        st_o.saved_index = (item_i.mode inside {eau_pkg::MODE_ZPY, eau_pkg::MODE_ABSY,
                                                eau_pkg::MODE_INDY}) ?
                           item_i.index_y : item_i.index_x;
        emit_o = 1'b1;
        if (item_i.mode == eau_pkg::MODE_IMM) begin
          res_o.kind              = eau_pkg::KIND_DONE;
          res_o.effective_address = item_i.pc;
          res_o.next_pc           = item_i.pc + 16'd1;
        end else begin
          st_o.phase        = eau_pkg::PH_OP_LO;
          res_o.kind        = eau_pkg::KIND_READ;
          res_o.bus_address = item_i.pc;
        end
      end
    end else begin
      case (st_i.phase)
        eau_pkg::PH_OP_LO: begin
          emit_o = 1'b1;
          case (st_i.active_mode)
            eau_pkg::MODE_ZP, eau_pkg::MODE_ZPX, eau_pkg::MODE_ZPY: begin
              st_o.phase              = eau_pkg::PH_IDLE;
              res_o.kind              = eau_pkg::KIND_DONE;
              res_o.effective_address = {8'h00,
                                         (st_i.active_mode == eau_pkg::MODE_ZP) ? b : zp_sum};
              res_o.next_pc           = st_i.saved_pc + 16'd1;
            end
            eau_pkg::MODE_INDX, eau_pkg::MODE_INDY: begin
              st_o.phase           = eau_pkg::PH_PTR_LO;
              st_o.pointer_address = {8'h00,
                                      (st_i.active_mode == eau_pkg::MODE_INDX) ? zp_sum : b};
              res_o.kind           = eau_pkg::KIND_READ;
              res_o.bus_address    = {8'h00,
                                      (st_i.active_mode == eau_pkg::MODE_INDX) ? zp_sum : b};
            end
            default: begin
              st_o.low_byte     = b;
              st_o.phase        = eau_pkg::PH_OP_HI;
              res_o.kind        = eau_pkg::KIND_READ;
              res_o.bus_address = st_i.saved_pc + 16'd1;
            end
          endcase
        end
        eau_pkg::PH_OP_HI: begin
          emit_o = 1'b1;
          if (st_i.active_mode == eau_pkg::MODE_IND) begin
            st_o.pointer_address = word;
            st_o.phase           = eau_pkg::PH_PTR_LO;
            res_o.kind           = eau_pkg::KIND_READ;
            res_o.bus_address    = word;
          end else begin
            st_o.phase              = eau_pkg::PH_IDLE;
            res_o.kind              = eau_pkg::KIND_DONE;
            res_o.effective_address =
              (st_i.active_mode inside {eau_pkg::MODE_ABSX, eau_pkg::MODE_ABSY}) ?
              word + {8'h00, st_i.saved_index} : word;
            res_o.next_pc           = st_i.saved_pc + 16'd2;
          end
        end
        eau_pkg::PH_PTR_LO: begin
          emit_o        = 1'b1;
          st_o.low_byte = b;
          st_o.phase    = eau_pkg::PH_PTR_HI;
          res_o.kind    = eau_pkg::KIND_READ;
          if (st_i.active_mode == eau_pkg::MODE_IND) begin
            // page-wrap bug: high byte comes from the start of the same page
            if (st_i.pointer_address[7:0] == eau_pkg::PageLastByte) begin
              res_o.bus_address = {st_i.pointer_address[15:8], 8'h00};
            end else begin
              res_o.bus_address = st_i.pointer_address + 16'd1;
            end
          end else begin
            res_o.bus_address = {8'h00, st_i.pointer_address[7:0] + 8'd1};
          end
        end
        eau_pkg::PH_PTR_HI: begin
          emit_o     = 1'b1;
          st_o.phase = eau_pkg::PH_IDLE;
          res_o.kind = eau_pkg::KIND_DONE;
          if (st_i.active_mode == eau_pkg::MODE_IND) begin
            res_o.effective_address = word;
            res_o.next_pc           = st_i.saved_pc + 16'd2;
          end else begin
            res_o.effective_address = (st_i.active_mode == eau_pkg::MODE_INDY) ?
                                      word + {8'h00, st_i.saved_index} : word;
            res_o.next_pc           = st_i.saved_pc + 16'd1;
          end
        end
        default: begin
          st_o.phase = eau_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cpu_effective_address_unit.sv */
// A word accepted into the input register is stepped combinationally from it;
//   any result lands in the output register, where out_valid_o rises.
// Throughput: one word per cycle; the input register takes a new word while
//   a result waits, stalling only when both are full and the output is stalled.
// Reset: rst_ni clears both valid flags and the address state (phase idle).
`default_nettype none

module cpu_effective_address_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire eau_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output eau_pkg::out_t      out_data_o
);

  logic            in_valid_q;
  eau_pkg::in_t    in_q;
  logic            out_valid_q;
  eau_pkg::out_t   out_q;
  eau_pkg::state_t state_q, state_d;
  logic            step_emit;
  eau_pkg::out_t   step_res;
  logic            out_free;
  logic            advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  eau_step u_step (
    .st_i   (state_q),
    .item_i (in_q),
    .st_o   (state_d),
    .emit_o (step_emit),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= advance && step_emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_emit) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_emit && step_res.kind == eau_pkg::KIND_DONE
    |=> state_q.phase == eau_pkg::PH_IDLE)
    else $error("phase not idle after finished result");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == eau_pkg::KIND_READ
    |-> out_q.effective_address == 16'h0000 && out_q.next_pc == 16'h0000)
    else $error("read request carries address result");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == eau_pkg::KIND_DONE |-> out_q.bus_address == 16'h0000)
    else $error("finished result carries bus address");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("held result overwritten");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a word");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  class address_scoreboard;
    eau_pkg::phase_e phase;
    logic [3:0]      active_mode;
    logic [15:0]     saved_pc;
    logic [7:0]      saved_index;
    logic [7:0]      low_byte;
    logic [15:0]     pointer_address;
    eau_pkg::out_t   expected_q[$];
    int unsigned     errors;

    function new();
      phase           = eau_pkg::PH_IDLE;
      active_mode     = '0;
      saved_pc        = '0;
      saved_index     = '0;
      low_byte        = '0;
      pointer_address = '0;
      errors          = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_read(logic [15:0] addr);
      eau_pkg::out_t r;
      r             = '0;
      r.kind        = eau_pkg::KIND_READ;
      r.bus_address = addr;
      expected_q.push_back(r);
    endfunction

    function void push_done(logic [15:0] ea, logic [15:0] adv);
      eau_pkg::out_t r;
      r                   = '0;
      r.kind              = eau_pkg::KIND_DONE;
      r.effective_address = ea;
      r.next_pc           = saved_pc + adv;
      expected_q.push_back(r);
      phase = eau_pkg::PH_IDLE;
    endfunction

    function void note_word(eau_pkg::in_t w);
      logic [7:0]  zp;
      logic [15:0] addr;
      if (w.op == eau_pkg::OP_START) begin
        if (phase != eau_pkg::PH_IDLE || w.mode > eau_pkg::MODE_INDY) return;
        active_mode = w.mode;
        saved_pc    = w.pc;
        saved_index = (w.mode == eau_pkg::MODE_ZPY || w.mode == eau_pkg::MODE_ABSY ||
                       w.mode == eau_pkg::MODE_INDY) ? w.index_y : w.index_x;
        if (w.mode == eau_pkg::MODE_IMM) begin
          push_done(w.pc, 16'd1);
        end else begin
          phase = eau_pkg::PH_OP_LO;
          push_read(w.pc);
        end
        return;
      end
      case (phase)
        eau_pkg::PH_OP_LO: begin
          case (active_mode)
            eau_pkg::MODE_ZP: push_done({8'h00, w.read_byte}, 16'd1);
            eau_pkg::MODE_ZPX, eau_pkg::MODE_ZPY:
              push_done({8'h00, w.read_byte + saved_index}, 16'd1);
            eau_pkg::MODE_INDX, eau_pkg::MODE_INDY: begin
              zp = (active_mode == eau_pkg::MODE_INDX) ? w.read_byte + saved_index :
                   w.read_byte;
              pointer_address = {8'h00, zp};
              phase = eau_pkg::PH_PTR_LO;
              push_read(pointer_address);
            end
            default: begin
              low_byte = w.read_byte;
              phase    = eau_pkg::PH_OP_HI;
              push_read(saved_pc + 16'd1);
            end
          endcase
        end
        eau_pkg::PH_OP_HI: begin
          addr = {w.read_byte, low_byte};
          if (active_mode == eau_pkg::MODE_IND) begin
            pointer_address = addr;
            phase = eau_pkg::PH_PTR_LO;
            push_read(addr);
          end else begin
            if (active_mode == eau_pkg::MODE_ABSX || active_mode == eau_pkg::MODE_ABSY)
              addr = addr + {8'h00, saved_index};
            push_done(addr, 16'd2);
          end
        end
        eau_pkg::PH_PTR_LO: begin
          low_byte = w.read_byte;
          phase    = eau_pkg::PH_PTR_HI;
          // indirect jump pointer at xxFF wraps within its page
          if (active_mode == eau_pkg::MODE_IND)
            push_read(pointer_address[7:0] == eau_pkg::PageLastByte ?
                      {pointer_address[15:8], 8'h00} : pointer_address + 16'd1);
          else
            push_read({8'h00, pointer_address[7:0] + 8'd1});
        end
        eau_pkg::PH_PTR_HI: begin
          addr = {w.read_byte, low_byte};
          if (active_mode == eau_pkg::MODE_INDY) addr = addr + {8'h00, saved_index};
          push_done(addr, (active_mode == eau_pkg::MODE_IND) ? 16'd2 : 16'd1);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(eau_pkg::out_t got);
      eau_pkg::out_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("bus_address", want.bus_address, got.bus_address);
      compare_field("effective_address", want.effective_address, got.effective_address);
      compare_field("next_pc", want.next_pc, got.next_pc);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  eau_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  eau_pkg::out_t out_data;

  address_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  cpu_effective_address_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_pc();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'hFFFE;
      2: return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int operand_reads(logic [3:0] m);
    case (m)
      eau_pkg::MODE_IMM: return 0;
      eau_pkg::MODE_ZP, eau_pkg::MODE_ZPX, eau_pkg::MODE_ZPY: return 1;
      eau_pkg::MODE_ABS, eau_pkg::MODE_ABSX, eau_pkg::MODE_ABSY: return 2;
      eau_pkg::MODE_IND: return 4;
      default: return 3;
    endcase
  endfunction

  task automatic offer_word(eau_pkg::in_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic send_start(logic [3:0] m, logic [15:0] pc, logic [7:0] x, logic [7:0] y);
    eau_pkg::in_t w;
    w.op        = eau_pkg::OP_START;
    w.mode      = m;
    w.pc        = pc;
    w.index_x   = x;
    w.index_y   = y;
    w.read_byte = 8'($urandom);
    offer_word(w);
  endtask

  task automatic send_byte(logic [7:0] b);
    eau_pkg::in_t w;
    w.op        = eau_pkg::OP_BYTE;
    w.mode      = 4'($urandom);
    w.pc        = 16'($urandom);
    w.index_x   = 8'($urandom);
    w.index_y   = 8'($urandom);
    w.read_byte = b;
    offer_word(w);
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    burst_left = 0;
  endtask

  // a cut sequence leaves the unit busy unless the mode is immediate; later starts are then dropped
  task automatic run_sequence(bit cut);
    logic [3:0] m;
    int n;
    m = 4'($urandom_range(0, 9));
    n = operand_reads(m);
    if (cut) n = (n == 0) ? 0 : $urandom_range(0, n - 1);
    send_start(m, rand_pc(), rand_byte(), rand_byte());
    words_sent++;
    for (int i = 0; i < n; i++) begin
      send_byte(rand_byte());
      words_sent++;
    end
  endtask

  initial begin
    int unsigned hold_pct;
    int unsigned seg_len;
    int unsigned cycles;
    bit long_done;
    out_stall = 1'b0;
    cycles    = 0;
    long_done = 0;
    @(posedge rst_n);
    forever begin
      if (!long_done && cycles >= 400) begin
        long_done = 1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        cycles += 300;
      end else begin
        seg_len = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: hold_pct = 0;
          1: hold_pct = 25;
          2: hold_pct = 75;
          default: hold_pct = 50;
        endcase
        repeat (seg_len) begin
          out_stall <= ($urandom_range(0, 99) < hold_pct);
          @(posedge clk);
          cycles++;
        end
      end
    end
  end

  initial begin
    eau_pkg::in_t w;
    int unsigned pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_start(eau_pkg::MODE_IMM, 16'hFFFF, 8'h00, 8'h00);
    send_byte(8'h5A);
    send_start(eau_pkg::MODE_ZP, 16'h0000, 8'hFF, 8'hFF);
    send_byte(8'hFF);
    send_start(eau_pkg::MODE_ZPX, 16'h1234, 8'hFF, 8'h00);
    send_byte(8'hFF);
    send_start(eau_pkg::MODE_ZPY, 16'h8000, 8'h00, 8'h81);
    send_byte(8'h80);
    send_start(eau_pkg::MODE_ABS, 16'hFFFF, 8'h00, 8'h00);
    send_byte(8'h34);
    send_start(eau_pkg::MODE_ZP, 16'h5555, 8'hAA, 8'h55);
    send_byte(8'h12);
    send_start(eau_pkg::MODE_ABSX, 16'h2000, 8'hFF, 8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_start(eau_pkg::MODE_ABSY, 16'hFFFE, 8'h00, 8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_start(eau_pkg::MODE_IND, 16'h0300, 8'h00, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h78);
    send_byte(8'h56);
    send_start(eau_pkg::MODE_INDX, 16'h4000, 8'h01, 8'h00);
    send_byte(8'hFE);
    send_byte(8'hCD);
    send_byte(8'hAB);
    send_start(eau_pkg::MODE_INDY, 16'hFFFF, 8'h00, 8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_start(4'($urandom_range(10, 15)), 16'hFFFF, 8'hFF, 8'hFF);
    drain_pause();

    while (words_sent < 1000) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        run_sequence(1'b0);
      end else if (pick < 88) begin
        run_sequence(1'b1);
      end else if (pick < 97) begin
        w.op        = 1'($urandom);
        w.mode      = 4'($urandom);
        w.pc        = 16'($urandom);
        w.index_x   = 8'($urandom);
        w.index_y   = 8'($urandom);
        w.read_byte = 8'($urandom);
        offer_word(w);
        words_sent++;
      end else begin
        drain_pause();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
